>>> sv/u8e_pkg.sv
// ----------------------------------------------------------------------------
// UCS-2 to UTF-8 encoder package
// Shared widths, character codes, register indexes and types.
// ----------------------------------------------------------------------------
package u8e_pkg;

	// Field widths.
	localparam int UNIT_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_BYTES = 5;
	localparam int CNT_W     = 3;

	// String phase codes.
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_ENDED = 2'd3;

	// Name modes; the unused code behaves as plain text.
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_NICK  = 2'd1;
	localparam logic [1:0] MODE_CHAN  = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NAME_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_CONTROLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_WILDCARD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NICK_PREFIX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_PREFIX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_CHAN  = 3'd5;

	// Character codes.
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LC_N  = 8'h6e;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_C  = 8'h63;

	// UTF-8 encoding constants.
	localparam logic [UNIT_W-1:0] MAX_ONE_BYTE = 16'h007f;
	localparam logic [UNIT_W-1:0] MAX_TWO_BYTE = 16'h07ff;
	localparam logic [7:0]        LEAD_TWO     = 8'hc0;
	localparam logic [7:0]        LEAD_THREE   = 8'he0;
	localparam logic [7:0]        CONT_MARK    = 8'h80;

	// Reset values of the registers.
	localparam logic [7:0] GLOBAL_CHAN_RESET = 8'd35;

	// Configuration register set.
	typedef struct packed {
		logic [1:0] name_mode;
		logic       escape_controls;
		logic       escape_wildcards;
		logic [7:0] nick_prefix_byte;
		logic [7:0] channel_prefix_byte;
		logic [7:0] global_channel_byte;
	} cfg_t;

	// Bytes caused by one code unit, in order, and how many are used.
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 cnt;
	} res_t;

endpackage

>>> sv/u8e_unit_if.sv
// ----------------------------------------------------------------------------
// Code unit channel
// Valid/ready channel carrying one UTF-16 code unit and its string marks.
// ----------------------------------------------------------------------------
interface u8e_unit_if;
	logic                        valid;
	logic                        ready;
	logic [u8e_pkg::UNIT_W-1:0]  code_unit;
	logic                        first_unit;
	logic                        last_unit;

	modport source (output valid, output code_unit, output first_unit,
		output last_unit, input ready);
	modport sink (input valid, input code_unit, input first_unit,
		input last_unit, output ready);
endinterface

>>> sv/u8e_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one encoded byte and its run end mark.
// ----------------------------------------------------------------------------
interface u8e_byte_if;
	logic                        valid;
	logic                        ready;
	logic [u8e_pkg::BYTE_W-1:0]  out_byte;
	logic                        run_end;

	modport source (output valid, output out_byte, output run_end, input ready);
	modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

>>> sv/u8e_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface u8e_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [u8e_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/u8e_encode.sv
// ----------------------------------------------------------------------------
// Code unit encoder
// Combinational encoding of one code unit into up to five bytes, with
// escapes, name prefixes and the next string phase.
// ----------------------------------------------------------------------------
module u8e_encode (
	input  u8e_pkg::cfg_t                cfg,
	input  logic [1:0]                   phase,
	input  logic [u8e_pkg::UNIT_W-1:0]   code_unit,
	input  logic                         first_unit,
	input  logic                         last_unit,
	output u8e_pkg::res_t                res,
	output logic [1:0]                   next_phase
);

	logic [1:0]       ph;
	logic             esc;
	logic [7:0]       esc_chr;
	logic [2:0][7:0]  e_bytes;
	logic [1:0]       e_cnt;
	logic [1:0][7:0]  h_bytes;
	logic [1:0]       h_cnt;
	logic             use_enc;
	logic             is_marker;

	// Escape detection for the body encoding.
	always_comb begin
		esc     = 1'b0;
		esc_chr = '0;
		if (cfg.escape_controls && code_unit[15:8] == 8'h00) begin
			case (code_unit[7:0])
				u8e_pkg::CH_LF: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_LC_N;
				end
				u8e_pkg::CH_CR: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_LC_R;
				end
				u8e_pkg::CH_TAB: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_LC_T;
				end
				u8e_pkg::CH_SPACE: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_LC_B;
				end
				u8e_pkg::CH_COMMA: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_LC_C;
				end
				u8e_pkg::CH_BSL: begin
					esc     = 1'b1;
					esc_chr = u8e_pkg::CH_BSL;
				end
				default: begin
					esc     = 1'b0;
					esc_chr = '0;
				end
			endcase
		end
		if (!esc && cfg.escape_wildcards &&
				(code_unit == {8'h00, u8e_pkg::CH_STAR} ||
				code_unit == {8'h00, u8e_pkg::CH_QUEST})) begin
			esc     = 1'b1;
			esc_chr = code_unit[7:0];
		end
	end

	// Body bytes: a backslash escape or one to three UTF-8 bytes.
	always_comb begin
		e_bytes = '0;
		if (esc) begin
			e_bytes[0] = u8e_pkg::CH_BSL;
			e_bytes[1] = esc_chr;
			e_cnt      = 2'd2;
		end else if (code_unit <= u8e_pkg::MAX_ONE_BYTE) begin
			e_bytes[0] = code_unit[7:0];
			e_cnt      = 2'd1;
		end else if (code_unit <= u8e_pkg::MAX_TWO_BYTE) begin
			e_bytes[0] = u8e_pkg::LEAD_TWO | {3'b000, code_unit[10:6]};
			e_bytes[1] = u8e_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
			e_cnt      = 2'd2;
		end else begin
			e_bytes[0] = u8e_pkg::LEAD_THREE | {4'b0000, code_unit[15:12]};
			e_bytes[1] = u8e_pkg::CONT_MARK | {2'b00, code_unit[11:6]};
			e_bytes[2] = u8e_pkg::CONT_MARK | {2'b00, code_unit[5:0]};
			e_cnt      = 2'd3;
		end
	end

	assign is_marker = code_unit == {8'h00, u8e_pkg::CH_HASH} ||
		code_unit == {8'h00, u8e_pkg::CH_AMP};

	// Head bytes and phase step from the string position and name mode.
	always_comb begin
		ph         = first_unit ? u8e_pkg::PH_START : phase;
		h_bytes    = '0;
		h_cnt      = 2'd0;
		use_enc    = 1'b0;
		next_phase = ph;
		if (ph == u8e_pkg::PH_ENDED) begin
			next_phase = u8e_pkg::PH_ENDED;
		end else if (code_unit == '0) begin
			// A zero unit ends the string; a pending percent still owes the global byte.
			if (ph == u8e_pkg::PH_PCT) begin
				h_bytes[0] = cfg.global_channel_byte;
				h_cnt      = 2'd1;
			end
			next_phase = u8e_pkg::PH_ENDED;
		end else if (ph == u8e_pkg::PH_BODY) begin
			use_enc = 1'b1;
		end else if (ph == u8e_pkg::PH_PCT) begin
			if (is_marker) begin
				h_bytes[0] = code_unit[7:0];
			end else begin
				h_bytes[0] = cfg.global_channel_byte;
				use_enc    = 1'b1;
			end
			h_cnt      = 2'd1;
			next_phase = u8e_pkg::PH_BODY;
		end else if (cfg.name_mode == u8e_pkg::MODE_NICK) begin
			h_bytes[0] = cfg.nick_prefix_byte;
			h_cnt      = 2'd1;
			use_enc    = 1'b1;
			next_phase = u8e_pkg::PH_BODY;
		end else if (cfg.name_mode == u8e_pkg::MODE_CHAN) begin
			h_bytes[0] = cfg.channel_prefix_byte;
			if (code_unit == {8'h00, u8e_pkg::CH_PCT}) begin
				// Leading percent is dropped; the global byte follows only if the string stops here.
				h_bytes[1] = cfg.global_channel_byte;
				h_cnt      = last_unit ? 2'd2 : 2'd1;
				next_phase = u8e_pkg::PH_PCT;
			end else if (is_marker) begin
				h_bytes[1] = code_unit[7:0];
				h_cnt      = 2'd2;
				next_phase = u8e_pkg::PH_BODY;
			end else begin
				h_bytes[1] = cfg.global_channel_byte;
				h_cnt      = 2'd2;
				use_enc    = 1'b1;
				next_phase = u8e_pkg::PH_BODY;
			end
		end else begin
			use_enc    = 1'b1;
			next_phase = u8e_pkg::PH_BODY;
		end
	end

	// Pack head bytes followed by body bytes into the result list.
	always_comb begin
		logic [2:0] iv;
		logic [2:0] j;
		res.bytes = '0;
		res.cnt   = {1'b0, h_cnt} + (use_enc ? {1'b0, e_cnt} : 3'd0);
		for (int i = 0; i < u8e_pkg::MAX_BYTES; i++) begin
			iv = 3'(i);
			j  = iv - {1'b0, h_cnt};
			if (iv < {1'b0, h_cnt}) begin
				res.bytes[i] = h_bytes[iv[0]];
			end else if (use_enc && j < 3'd3) begin
				res.bytes[i] = e_bytes[j[1:0]];
			end
		end
	end

endmodule

>>> sv/u8e_byte_buf.sv
// ----------------------------------------------------------------------------
// Result byte buffer
// Holds the byte list of one code unit and hands it out one byte per beat.
// ----------------------------------------------------------------------------
module u8e_byte_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  u8e_pkg::res_t     load_res,
	output logic              load_ready,
	u8e_byte_if.source        byte_ch
);

	logic                                      valid_s2;
	logic [u8e_pkg::MAX_BYTES-1:0][7:0]        bytes_s2;
	logic [u8e_pkg::CNT_W-1:0]                 cnt_s2;
	logic [u8e_pkg::CNT_W-1:0]                 idx_s2;
	logic                                      at_last;
	logic                                      beat;

	assign at_last    = idx_s2 == cnt_s2 - 3'd1;
	assign beat       = byte_ch.valid && byte_ch.ready;
	assign load_ready = !valid_s2 || (beat && at_last);

	// Control: occupancy and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (load_valid && load_ready) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (beat) begin
			if (at_last) begin
				valid_s2 <= 1'b0;
			end
			idx_s2 <= idx_s2 + 3'd1;
		end
	end

	// Payload: the byte list itself.
	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			bytes_s2 <= load_res.bytes;
			cnt_s2   <= load_res.cnt;
		end
	end

	assign byte_ch.valid    = valid_s2;
	assign byte_ch.out_byte = bytes_s2[idx_s2];
	assign byte_ch.run_end  = at_last;

	// The buffer only ever holds a nonempty list.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 != 3'd0 && cnt_s2 <= 3'(u8e_pkg::MAX_BYTES)))
		else $error("byte buffer holds an empty or oversized list");

	// The byte position never runs past the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_s2 < cnt_s2)
		else $error("byte position beyond list length");

	// A beat that is not the run end steps to the next byte of the same list.
	assert property (@(posedge clk) disable iff (!arst_n)
		(beat && !at_last) |=> (valid_s2 && idx_s2 == $past(idx_s2) + 3'd1))
		else $error("byte position did not advance within a run");

endmodule

>>> sv/ucs2_to_utf8_escaping_encoder_top.sv
// ----------------------------------------------------------------------------
// UCS-2 to UTF-8 escaping encoder
// Turns a stream of 16-bit code units into UTF-8 bytes with optional
// backslash escapes and nickname or channel name prefixes.
// ----------------------------------------------------------------------------
// Usage:
//   unit_ch takes one code unit per beat, marked first or last of a string.
//   byte_ch gives one byte per beat; run_end marks the last byte of a unit.
//   A unit gives zero to five bytes; a unit that gives none produces no beat.
//   cfg writes registers 0 to 5 (mode, escapes, prefix bytes); it is always
//   ready and is meant to be used only while the encoder is idle.
// Each unit is registered in the input register and then in the byte buffer before its first byte is valid.
// Throughput: one unit per cycle while units give at most one byte and byte_ch
//   is ready; otherwise the pace is set by the byte-wide output buffer, which
//   hands out one byte per cycle while byte_ch is ready.
// A stalled byte_ch holds the current byte; one further unit waits in the
//   input register, after which unit_ch drops ready.
// Reset clears the registers to their defaults (global channel byte 35),
// empties both stages and returns the string phase to start of string.
// ----------------------------------------------------------------------------
module ucs2_to_utf8_escaping_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	u8e_unit_if.sink    unit_ch,
	u8e_byte_if.source  byte_ch,
	u8e_cfg_if.sink     cfg
);

	u8e_pkg::cfg_t                   cfg_q;
	logic [1:0]                      phase_q;
	logic                            valid_s1;
	logic [u8e_pkg::UNIT_W-1:0]      unit_s1;
	logic                            first_s1;
	logic                            last_s1;
	u8e_pkg::res_t                   enc_res;
	logic [1:0]                      enc_next;
	logic                            load_ready;
	logic                            adv_s1;
	logic                            unit_beat;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_mode           <= u8e_pkg::MODE_PLAIN;
			cfg_q.escape_controls     <= 1'b0;
			cfg_q.escape_wildcards    <= 1'b0;
			cfg_q.nick_prefix_byte    <= '0;
			cfg_q.channel_prefix_byte <= '0;
			cfg_q.global_channel_byte <= u8e_pkg::GLOBAL_CHAN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				u8e_pkg::REG_NAME_MODE:    cfg_q.name_mode           <= cfg.data[1:0];
				u8e_pkg::REG_ESC_CONTROLS: cfg_q.escape_controls     <= cfg.data[0];
				u8e_pkg::REG_ESC_WILDCARD: cfg_q.escape_wildcards    <= cfg.data[0];
				u8e_pkg::REG_NICK_PREFIX:  cfg_q.nick_prefix_byte    <= cfg.data;
				u8e_pkg::REG_CHAN_PREFIX:  cfg_q.channel_prefix_byte <= cfg.data;
				u8e_pkg::REG_GLOBAL_CHAN:  cfg_q.global_channel_byte <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Input register stage.
	assign unit_beat     = unit_ch.valid && unit_ch.ready;
	assign adv_s1        = valid_s1 && (enc_res.cnt == '0 || load_ready);
	assign unit_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (unit_beat) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unit_beat) begin
			unit_s1  <= unit_ch.code_unit;
			first_s1 <= unit_ch.first_unit;
			last_s1  <= unit_ch.last_unit;
		end
	end

	// String phase steps as each unit leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= u8e_pkg::PH_START;
		end else if (adv_s1) begin
			phase_q <= last_s1 ? u8e_pkg::PH_START : enc_next;
		end
	end

	u8e_encode u_encode (
		.cfg        (cfg_q),
		.phase      (phase_q),
		.code_unit  (unit_s1),
		.first_unit (first_s1),
		.last_unit  (last_s1),
		.res        (enc_res),
		.next_phase (enc_next)
	);

	u8e_byte_buf u_byte_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1 && enc_res.cnt != '0),
		.load_res   (enc_res),
		.load_ready (load_ready),
		.byte_ch    (byte_ch)
	);

	// A unit marked last returns the phase to start of string.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> phase_q == u8e_pkg::PH_START)
		else $error("phase not back at start after last unit");

	// A held unit that gives bytes stays in the input register until the buffer frees.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(unit_s1)))
		else $error("input register lost a waiting unit");

	// Units in an ended string never produce bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !first_s1 && phase_q == u8e_pkg::PH_ENDED) |-> enc_res.cnt == '0)
		else $error("bytes produced after the end of a string");

endmodule
